>>> hdl/crv_pkg.sv
// shared types, constants and the byte-wise crc-32 step for the calibration record validator
// no dependencies
package crv_pkg;

  localparam int unsigned RecBytes = 20;
  localparam int unsigned CrcBytes = 16;
  localparam int unsigned PosW     = 5;

  localparam logic [PosW-1:0] LastPos = PosW'(RecBytes - 1);

  localparam logic [31:0] CrcPoly    = 32'hedb88320;
  localparam logic [31:0] CrcInit    = 32'hffffffff;
  localparam logic [31:0] RecMagic   = 32'h41433543;
  localparam logic [15:0] RecVersion = 16'd1;
  localparam logic [15:0] RecLength  = 16'(RecBytes);

  localparam logic [7:0]  PedMin  = 8'd12;
  localparam logic [7:0]  PedMax  = 8'd28;
  localparam logic [7:0]  GainMin = 8'd1;
  localparam logic [7:0]  GainMax = 8'd4;
  localparam logic [7:0]  PolMax  = 8'd1;
  localparam logic [31:0] ClkMin  = 32'd10000000;
  localparam logic [31:0] ClkMax  = 32'd20500000;

  localparam logic [4:0]  DefPed  = 5'd20;
  localparam logic [2:0]  DefGain = 3'd2;
  localparam logic        DefPol  = 1'b0;
  localparam logic [24:0] DefClk  = 25'd20000000;

  typedef struct packed {
    logic [7:0] rec_byte;
    logic       fault;
  } item_t;

  // record as seen at its last byte
  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] length;
    logic [7:0]  ped;
    logic [7:0]  gain;
    logic [7:0]  pol;
    logic [31:0] clk;
    logic [31:0] stored_crc;
    logic [31:0] running_crc;
    logic        fault;
  } rec_t;

  typedef struct packed {
    logic [4:0]  ped_code;
    logic [2:0]  disc_gain;
    logic        polarity;
    logic [24:0] out_clk_hz;
    logic        from_record;
  } result_t;

  // reflected crc-32, one byte, eight shift steps
  function automatic logic [31:0] crc32_byte(logic [31:0] crc_in, logic [7:0] data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      crc = {1'b0, crc[31:1]} ^ (CrcPoly & {32{crc[0]}});
    end
    return crc;
  endfunction

endpackage

>>> hdl/crv_in_reg.sv
// input register stage of the calibration record validator
// depends on crv_pkg
module crv_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     record_byte_i,
  input  logic           read_fault_i,
  input  logic           advance_i,
  output logic           item_valid_o,
  output crv_pkg::item_t item_o
);
  import crv_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{rec_byte: record_byte_i, fault: read_fault_i};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> hdl/crv_accum.sv
// byte position, running crc and field capture for one record
// depends on crv_pkg
module crv_accum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  crv_pkg::item_t item_i,
  output logic           is_last_o,
  output crv_pkg::rec_t  rec_o
);
  import crv_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     crc_q, crc_d;
  logic            fault_q, fault_d;
  logic [63:0]     hdr_q;
  logic [63:0]     set_q;
  logic [23:0]     chk_q;

  assign is_last_o = (pos_q == LastPos);

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    fault_d = fault_q;
    if (advance_i) begin
      if (is_last_o) begin
        pos_d   = '0;
        crc_d   = CrcInit;
        fault_d = 1'b0;
      end else begin
        pos_d   = pos_q + 1'b1;
        fault_d = fault_q || item_i.fault;
        if (pos_q < PosW'(CrcBytes)) begin
          crc_d = crc32_byte(crc_q, item_i.rec_byte);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= CrcInit;
      fault_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      fault_q <= fault_d;
    end
  end

  // every byte slot is rewritten in each record, so no clearing is needed
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      if (pos_q < 5'd8) begin
        hdr_q[{pos_q[2:0], 3'b000} +: 8] <= item_i.rec_byte;
      end else if (pos_q < 5'd16) begin
        set_q[{pos_q[2:0], 3'b000} +: 8] <= item_i.rec_byte;
      end else if (!is_last_o) begin
        chk_q[{pos_q[1:0], 3'b000} +: 8] <= item_i.rec_byte;
      end
    end
  end

  // the last byte completes the stored checksum
  always_comb begin
    rec_o.magic       = hdr_q[31:0];
    rec_o.version     = hdr_q[47:32];
    rec_o.length      = hdr_q[63:48];
    rec_o.ped         = set_q[7:0];
    rec_o.gain        = set_q[15:8];
    rec_o.pol         = set_q[23:16];
    rec_o.clk         = set_q[63:32];
    rec_o.stored_crc  = {item_i.rec_byte, chk_q};
    rec_o.running_crc = crc_q;
    rec_o.fault       = fault_q || item_i.fault;
  end

endmodule

>>> hdl/crv_check.sv
// record checks and selection between record values and defaults
// depends on crv_pkg
module crv_check (
  input  crv_pkg::rec_t    rec_i,
  output crv_pkg::result_t result_o
);
  import crv_pkg::*;

  logic ok;

  always_comb begin
    ok = !rec_i.fault
      && (rec_i.magic == RecMagic)
      && (rec_i.version == RecVersion)
      && (rec_i.length == RecLength)
      && (rec_i.stored_crc == ~rec_i.running_crc)
      && (rec_i.ped >= PedMin) && (rec_i.ped <= PedMax)
      && (rec_i.gain >= GainMin) && (rec_i.gain <= GainMax)
      && (rec_i.pol <= PolMax)
      && (rec_i.clk >= ClkMin) && (rec_i.clk <= ClkMax);

    if (ok) begin
      result_o.ped_code    = rec_i.ped[4:0];
      result_o.disc_gain   = rec_i.gain[2:0];
      result_o.polarity    = rec_i.pol[0];
      result_o.out_clk_hz  = rec_i.clk[24:0];
      result_o.from_record = 1'b1;
    end else begin
      result_o.ped_code    = DefPed;
      result_o.disc_gain   = DefGain;
      result_o.polarity    = DefPol;
      result_o.out_clk_hz  = DefClk;
      result_o.from_record = 1'b0;
    end
  end

endmodule

>>> hdl/calibration_record_validator.sv
// channel  | handshake                 | payload
// input    | in_valid_i / in_ready_o   | record_byte_i, read_fault_i
// output   | out_valid_o / out_ready_i | ped_code_o, disc_gain_o, polarity_o,
//          |                           | out_clk_hz_o, from_record_o
//
// one byte per cycle while no untaken result stalls the last byte; a record's last byte
// passes through the input register, then its result is loaded into the result register
// rst_ni clears position, crc, fault flag and both valid flags; no clearing pass
// bytes keep flowing while a result waits; only the last byte of the next record
// stalls behind an untaken result register
// top level: depends on crv_pkg, crv_in_reg, crv_accum, crv_check
module calibration_record_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  record_byte_i,
  input  logic        read_fault_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  ped_code_o,
  output logic [2:0]  disc_gain_o,
  output logic        polarity_o,
  output logic [24:0] out_clk_hz_o,
  output logic        from_record_o
);
  import crv_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    is_last;
  logic    advance;
  logic    res_free;
  rec_t    rec;
  result_t result;
  logic    out_valid_q, out_valid_d;
  result_t res_q;

  assign res_free = !out_valid_q || out_ready_i;
  assign advance  = item_valid && (!is_last || res_free);

  crv_in_reg u_in_reg (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .record_byte_i,
    .read_fault_i,
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  crv_accum u_accum (
    .clk_i,
    .rst_ni,
    .advance_i (advance),
    .item_i    (item),
    .is_last_o (is_last),
    .rec_o     (rec)
  );

  crv_check u_check (
    .rec_i    (rec),
    .result_o (result)
  );

  assign out_valid_d = (advance && is_last) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_last) begin
      res_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ped_code_o    = res_q.ped_code;
  assign disc_gain_o   = res_q.disc_gain;
  assign polarity_o    = res_q.polarity;
  assign out_clk_hz_o  = res_q.out_clk_hz;
  assign from_record_o = res_q.from_record;

endmodule

>>> hdl/crv_checker.sv
// port-level assertions for the calibration record validator, bound to the top level
// depends on calibration_record_validator
module crv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  record_byte_i,
  input logic        read_fault_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  ped_code_o,
  input logic [2:0]  disc_gain_o,
  input logic        polarity_o,
  input logic [24:0] out_clk_hz_o,
  input logic        from_record_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(ped_code_o) && $stable(from_record_o)
      && $stable(disc_gain_o) && $stable(polarity_o) && $stable(out_clk_hz_o))
    else $error("result changed while stalled");

  // rejected records give exactly the defaults
  a_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !from_record_o |-> ped_code_o == 5'd20
      && disc_gain_o == 3'd2 && polarity_o == 1'b0
      && out_clk_hz_o == 25'd20000000)
    else $error("default result wrong");

  // accepted records lie in the checked ranges
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && from_record_o |-> ped_code_o >= 5'd12 && ped_code_o <= 5'd28
      && disc_gain_o >= 3'd1 && disc_gain_o <= 3'd4
      && out_clk_hz_o >= 25'd10000000 && out_clk_hz_o <= 25'd20500000)
    else $error("accepted record out of range");

endmodule

bind calibration_record_validator crv_checker u_crv_checker (.*);
